/* hw/rtl/bladsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bladsc_pkg
// Shared constants, types and helper functions of the block luma ASCII
// downsampler.
// ----------------------------------------------------------------------------
package bladsc_pkg;

    localparam int CELL_WIDTH   = 8;
    localparam int CELL_HEIGHT  = 16;
    localparam int GRID_COLUMNS = 80;
    localparam int GRID_ROWS    = 25;
    localparam int RAMP_LENGTH  = 10;
    localparam int TABLE_LEN    = 10;

    localparam int LUMA_R    = 299;
    localparam int LUMA_G    = 587;
    localparam int LUMA_B    = 114;
    localparam int PIXEL_MAX = 'hFF;
    localparam int NORM_DIV  = 1000;

    localparam int SIZE_W   = 12;
    localparam int SIZE_MAX = 2048;
    localparam int POS_W    = 11;
    localparam int RGB_W    = 24;
    localparam int GLYPH_W  = 7;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam int LUMA_W = 18;
    localparam int SUM_W  = 34;
    localparam int CNT_W  = 16;
    localparam int DIV_W  = CNT_W + 10;
    localparam int NORM_W = 8;
    localparam int STEP_W = $clog2(NORM_W);

    localparam int COL_IDX_W   = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
    localparam int ROW_IDX_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int RAMP_IDX_W  = $clog2(RAMP_LENGTH);
    localparam int TABLE_IDX_W = $clog2(TABLE_LEN);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [GLYPH_W-1:0] GLYPH_TABLE [TABLE_LEN] = '{
        7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D, 7'h2B, 7'h2A, 7'h23, 7'h25, 7'h40
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_EMIT
    } bladsc_state_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } cell_acc_t;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     dividend;
        logic [DIV_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [NORM_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] result;
        if (size == '0) begin
            result = SIZE_W'(1);
        end else if (size > SIZE_W'(SIZE_MAX)) begin
            result = SIZE_W'(SIZE_MAX);
        end else begin
            result = size;
        end
        return result;
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [NORM_W-1:0] norm);
        logic [RAMP_IDX_W-1:0] idx;
        idx = '0;
        for (int k = 1; k < RAMP_LENGTH; k++) begin
            if (int'(norm) * (RAMP_LENGTH - 1) >= PIXEL_MAX * k) begin
                idx = idx + RAMP_IDX_W'(1);
            end
        end
        if (int'(idx) > TABLE_LEN - 1) begin
            idx = RAMP_IDX_W'(TABLE_LEN - 1);
        end
        return GLYPH_TABLE[TABLE_IDX_W'(idx)];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/bladsc_cell_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bladsc_cell_ram
// Single-port-write, single-port-read synchronous RAM with registered read
// data.
// ----------------------------------------------------------------------------
module bladsc_cell_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bladsc_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bladsc_divider
// Restoring divider that produces one quotient bit per cycle for quotients
// known to fit in NORM_W bits.
// ----------------------------------------------------------------------------
module bladsc_divider
    import bladsc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  dsh_reg;
    logic [NORM_W-1:0] q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NORM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.dividend;
            dsh_reg <= SUM_W'(req.divisor) << (NORM_W - 1);
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[NORM_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule
`default_nettype wire

/* hw/rtl/block_luma_ascii_downsampler_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_luma_ascii_downsampler_core
// Accumulates BT.601 luma of RGB pixels over 8x16 pixel cells and emits one
// ASCII ramp character for every cell of the grid that closes.
//
// Pixels arrive in raster order on the s_ channel, one word per pixel;
// s_frame_start marks the first pixel of a frame. Finished cells leave on the
// m_ channel with their glyph, text column and row, and row and frame end
// flags. Frame width and height are written through the cfg_ channel, which
// is always ready; index 0 is the width and index 1 the height.
// A pixel that does not close a cell is handled by a read of the column
// accumulator from the cell RAM and an add that writes it back.
// A pixel that closes a cell goes through the read, the update, the
// bit-serial divider (eight quotient bits, then a flag for the result) and
// a step that loads the output register.
// The output register lets the block take the next pixel while a result
// waits; when the receiver stalls and a second result is ready, the block
// holds it and takes no pixel until the output register frees up.
// After reset the size is 640 by 400, the position is the top left corner and
// every accumulator reads as empty.
// ----------------------------------------------------------------------------
module block_luma_ascii_downsampler_core
    import bladsc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [RGB_W-1:0]     s_pixel_rgb,
    input  wire logic                 s_frame_start,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [GLYPH_W-1:0]   m_glyph,
    output logic      [COLUMN_W-1:0]  m_cell_column,
    output logic      [ROW_W-1:0]     m_cell_row,
    output logic                      m_row_last,
    output logic                      m_frame_last
);

    bladsc_state_t state_reg;
    bladsc_state_t state_next;

    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;
    logic [POS_W-1:0]  pixel_column_reg;
    logic [POS_W-1:0]  pixel_line_reg;
    logic [GRID_COLUMNS-1:0] valid_reg;

    logic [LUMA_W-1:0]    luma_reg;
    logic [COL_IDX_W-1:0] tx_reg;
    logic [ROW_IDX_W-1:0] ty_reg;
    logic                 in_grid_reg;
    logic                 close_reg;
    logic                 row_end_reg;
    logic                 frame_end_reg;

    logic                 out_valid_reg;
    logic [GLYPH_W-1:0]   out_glyph_reg;
    logic [COLUMN_W-1:0]  out_column_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic                 out_row_last_reg;
    logic                 out_frame_last_reg;

    logic              accept;
    logic              load_out;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  line;
    logic [POS_W-1:0]  tx_full;
    logic [POS_W-1:0]  ty_full;
    logic [SIZE_W:0]   x_end;
    logic [SIZE_W:0]   y_end;
    logic [SIZE_W:0]   last_x;
    logic [SIZE_W:0]   last_y;
    logic [SIZE_W:0]   used_cols;
    logic [SIZE_W:0]   used_rows;
    logic [SIZE_W:0]   col_inc;
    logic [SIZE_W:0]   line_inc;
    logic [POS_W-1:0]  col_next;
    logic [POS_W-1:0]  line_next;
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic [LUMA_W-1:0] luma;

    cell_acc_t         rd_acc;
    cell_acc_t         old_acc;
    cell_acc_t         new_acc;
    logic              ram_wr_en;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;

    assign w_eff = effective_size(frame_width_reg);
    assign h_eff = effective_size(frame_height_reg);

    assign col     = s_frame_start ? '0 : pixel_column_reg;
    assign line    = s_frame_start ? '0 : pixel_line_reg;
    assign tx_full = POS_W'(col / CELL_WIDTH);
    assign ty_full = POS_W'(line / CELL_HEIGHT);

    assign x_end  = (SIZE_W + 1)'(tx_full) * (SIZE_W + 1)'(CELL_WIDTH)
                  + (SIZE_W + 1)'(CELL_WIDTH);
    assign y_end  = (SIZE_W + 1)'(ty_full) * (SIZE_W + 1)'(CELL_HEIGHT)
                  + (SIZE_W + 1)'(CELL_HEIGHT);
    assign last_x = ((x_end < (SIZE_W + 1)'(w_eff)) ? x_end : (SIZE_W + 1)'(w_eff))
                  - (SIZE_W + 1)'(1);
    assign last_y = ((y_end < (SIZE_W + 1)'(h_eff)) ? y_end : (SIZE_W + 1)'(h_eff))
                  - (SIZE_W + 1)'(1);

    always_comb begin
        used_cols = (SIZE_W + 1)'(((SIZE_W + 1)'(w_eff) + (SIZE_W + 1)'(CELL_WIDTH - 1))
                                  / CELL_WIDTH);
        if (used_cols > (SIZE_W + 1)'(GRID_COLUMNS)) begin
            used_cols = (SIZE_W + 1)'(GRID_COLUMNS);
        end
        used_rows = (SIZE_W + 1)'(((SIZE_W + 1)'(h_eff) + (SIZE_W + 1)'(CELL_HEIGHT - 1))
                                  / CELL_HEIGHT);
        if (used_rows > (SIZE_W + 1)'(GRID_ROWS)) begin
            used_rows = (SIZE_W + 1)'(GRID_ROWS);
        end
    end

    always_comb begin
        col_inc  = (SIZE_W + 1)'(col) + (SIZE_W + 1)'(1);
        line_inc = (SIZE_W + 1)'(line) + (SIZE_W + 1)'(1);
        if (col_inc >= (SIZE_W + 1)'(w_eff)) begin
            col_next = '0;
            if (line_inc >= (SIZE_W + 1)'(h_eff)) begin
                line_next = '0;
            end else begin
                line_next = line_inc[POS_W-1:0];
            end
        end else begin
            col_next  = col_inc[POS_W-1:0];
            line_next = line;
        end
    end

    assign r    = s_pixel_rgb[23:16];
    assign g    = s_pixel_rgb[15:8];
    assign b    = s_pixel_rgb[7:0];
    assign luma = LUMA_W'(r) * LUMA_W'(LUMA_R) + LUMA_W'(g) * LUMA_W'(LUMA_G)
                + LUMA_W'(b) * LUMA_W'(LUMA_B);

    bladsc_cell_ram #(
        .WIDTH ($bits(cell_acc_t)),
        .DEPTH (GRID_COLUMNS),
        .ADDR_W(COL_IDX_W)
    ) u_cell_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(tx_reg),
        .wr_data(new_acc),
        .rd_en  (accept),
        .rd_addr(COL_IDX_W'(tx_full)),
        .rd_data(rd_acc)
    );

    assign old_acc       = valid_reg[tx_reg] ? rd_acc : '0;
    assign new_acc.sum   = old_acc.sum + SUM_W'(luma_reg);
    assign new_acc.count = old_acc.count + CNT_W'(1);
    assign ram_wr_en     = (state_reg == ST_ACC) && in_grid_reg && !close_reg;

    assign div_req.start    = (state_reg == ST_ACC) && in_grid_reg && close_reg;
    assign div_req.dividend = new_acc.sum;
    assign div_req.divisor  = DIV_W'(new_acc.count) * DIV_W'(NORM_DIV);

    bladsc_divider u_divider (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (in_grid_reg && close_reg) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= SIZE_W'(640);
            frame_height_reg <= SIZE_W'(400);
            pixel_column_reg <= '0;
            pixel_line_reg   <= '0;
            valid_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FRAME_WIDTH) begin
                    frame_width_reg <= cfg_data;
                end else if (cfg_index == CFG_FRAME_HEIGHT) begin
                    frame_height_reg <= cfg_data;
                end
            end
            if (accept) begin
                pixel_column_reg <= col_next;
                pixel_line_reg   <= line_next;
                if (s_frame_start) begin
                    valid_reg <= '0;
                end
            end
            if (state_reg == ST_ACC && in_grid_reg) begin
                valid_reg[tx_reg] <= !close_reg;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            luma_reg      <= luma;
            tx_reg        <= COL_IDX_W'(tx_full);
            ty_reg        <= ROW_IDX_W'(ty_full);
            in_grid_reg   <= (tx_full < POS_W'(GRID_COLUMNS)) && (ty_full < POS_W'(GRID_ROWS));
            close_reg     <= ((SIZE_W + 1)'(col) == last_x) && ((SIZE_W + 1)'(line) == last_y);
            row_end_reg   <= (SIZE_W + 1)'(tx_full) == used_cols - (SIZE_W + 1)'(1);
            frame_end_reg <= (SIZE_W + 1)'(ty_full) == used_rows - (SIZE_W + 1)'(1);
        end
        if (load_out) begin
            out_glyph_reg      <= glyph_of(div_rsp.quotient);
            out_column_reg     <= COLUMN_W'(tx_reg);
            out_row_reg        <= ROW_W'(ty_reg);
            out_row_last_reg   <= row_end_reg;
            out_frame_last_reg <= row_end_reg && frame_end_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_glyph       = out_glyph_reg;
    assign m_cell_column = out_column_reg;
    assign m_cell_row    = out_row_reg;
    assign m_row_last    = out_row_last_reg;
    assign m_frame_last  = out_frame_last_reg;

    // The divider finishes only while the controller waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    // An accepted pixel always moves on to the accumulate step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_ACC)
        else $error("accepted pixel did not reach the accumulate step");

    // A result word is loaded only for a cell that lies on the grid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid && (m_cell_column < COLUMN_W'(GRID_COLUMNS))
                     && (m_cell_row < ROW_W'(GRID_ROWS)))
        else $error("result word outside the cell grid");

    // The last cell of a frame is always the last cell of its row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_last) |-> m_row_last)
        else $error("frame end without row end");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the block luma ASCII downsampler core.
//
// A short table of directed pixels and frame sizes comes first. It covers the
// color extremes, a one-pixel frame, a zero size, a two by two cell and a
// line split over two cells. Random phases follow: whole frames of small
// sizes, resizes in the middle of a frame, stray frame starts, odd register
// values, and the start of a 2048-pixel line and of a 2048-line column.
// Every pixel is run through a cycle-free model of the cell accumulators,
// and each cell word that leaves the block is checked field by field
// against the oldest expected cell, as the model or the table gives it.
// ----------------------------------------------------------------------------
module tb
    import bladsc_pkg::*;
();

    localparam int PIXEL_TARGET     = 1650;
    localparam int DRAIN_CYCLES     = 20;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PRINT_LIMIT      = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    typedef struct packed {
        logic [GLYPH_W-1:0]  glyph;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic                row_last;
        logic                frame_last;
    } cell_word_t;

    typedef enum {
        ROW_PIXEL,
        ROW_SIZES
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [RGB_W-1:0]   rgb;
        logic               frame_start;
        bit                 known;
        cell_word_t         want;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    logic                 s_valid;
    logic                 s_ready;
    logic [RGB_W-1:0]     s_pixel_rgb;
    logic                 s_frame_start;

    logic                 m_valid;
    logic                 m_ready;
    logic [GLYPH_W-1:0]   m_glyph;
    logic [COLUMN_W-1:0]  m_cell_column;
    logic [ROW_W-1:0]     m_cell_row;
    logic                 m_row_last;
    logic                 m_frame_last;

    block_luma_ascii_downsampler_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_rgb   (s_pixel_rgb),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_glyph       (m_glyph),
        .m_cell_column (m_cell_column),
        .m_cell_row    (m_cell_row),
        .m_row_last    (m_row_last),
        .m_frame_last  (m_frame_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    string ramp_chars = " .:-=+*#%@";

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    longint unsigned   luma_sum [GRID_COLUMNS];
    int unsigned       sample_count [GRID_COLUMNS];
    logic [POS_W-1:0]  pos_col;
    logic [POS_W-1:0]  pos_line;

    cell_word_t expected_cells [$];
    stim_row_t  directed_rows [$];

    int  mismatches    = 0;
    int  pixels_sent   = 0;
    int  words_taken   = 0;
    int  hold_requests = 0;
    bit  source_pauses = 1'b0;
    bit  sink_pauses   = 1'b0;
    int  shade_lo      = 0;
    int  shade_hi      = 255;

    function automatic int unsigned size_in_use(input logic [SIZE_W-1:0] value);
        if (value == '0) begin
            return 1;
        end
        if (value > SIZE_W'(SIZE_MAX)) begin
            return SIZE_MAX;
        end
        return 32'(value);
    endfunction

    function automatic void clear_cells();
        foreach (luma_sum[i]) begin
            luma_sum[i] = 0;
            sample_count[i] = 0;
        end
    endfunction

    function automatic void predict_pixel(input logic [RGB_W-1:0] rgb, input logic starts_frame,
                                          output bit hit, output cell_word_t closed);
        int unsigned     w, h, xpos, ypos, cx, cy, last_x, last_y;
        int unsigned     used_cols, used_rows, luma, idx;
        longint unsigned avg, level;
        byte             code;
        w = size_in_use(width_reg);
        h = size_in_use(height_reg);
        hit = 1'b0;
        closed = '0;
        if (starts_frame) begin
            pos_col = '0;
            pos_line = '0;
            clear_cells();
        end
        xpos = 32'(pos_col);
        ypos = 32'(pos_line);
        cx = xpos / CELL_WIDTH;
        cy = ypos / CELL_HEIGHT;
        if (cx < GRID_COLUMNS && cy < GRID_ROWS) begin
            luma = LUMA_R * rgb[23:16] + LUMA_G * rgb[15:8] + LUMA_B * rgb[7:0];
            luma_sum[cx] += 64'(luma);
            sample_count[cx] += 1;
            last_x = ((cx * CELL_WIDTH + CELL_WIDTH < w) ? cx * CELL_WIDTH + CELL_WIDTH : w) - 1;
            last_y = ((cy * CELL_HEIGHT + CELL_HEIGHT < h) ? cy * CELL_HEIGHT + CELL_HEIGHT : h) - 1;
            if (xpos == last_x && ypos == last_y) begin
                avg = luma_sum[cx] / sample_count[cx];
                level = avg / NORM_DIV;
                idx = int'(level * (RAMP_LENGTH - 1) / PIXEL_MAX);
                if (idx > RAMP_LENGTH - 1) begin
                    idx = RAMP_LENGTH - 1;
                end
                if (idx > TABLE_LEN - 1) begin
                    idx = TABLE_LEN - 1;
                end
                used_cols = (w + CELL_WIDTH - 1) / CELL_WIDTH;
                if (used_cols > GRID_COLUMNS) begin
                    used_cols = GRID_COLUMNS;
                end
                used_rows = (h + CELL_HEIGHT - 1) / CELL_HEIGHT;
                if (used_rows > GRID_ROWS) begin
                    used_rows = GRID_ROWS;
                end
                code = ramp_chars[idx];
                closed.glyph = code[GLYPH_W-1:0];
                closed.column = COLUMN_W'(cx);
                closed.row = ROW_W'(cy);
                closed.row_last = (cx == used_cols - 1);
                closed.frame_last = (cx == used_cols - 1) && (cy == used_rows - 1);
                hit = 1'b1;
                luma_sum[cx] = 0;
                sample_count[cx] = 0;
            end
        end
        xpos += 1;
        if (xpos >= w) begin
            xpos = 0;
            ypos += 1;
            if (ypos >= h) begin
                ypos = 0;
            end
        end
        pos_col = POS_W'(xpos);
        pos_line = POS_W'(ypos);
    endfunction

    function automatic void add_pixel_row(input logic [RGB_W-1:0] rgb, input logic fs);
        stim_row_t r;
        r = '{kind: ROW_PIXEL, rgb: rgb, frame_start: fs, known: 1'b0, want: '0,
              width: '0, height: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_known_row(input logic [RGB_W-1:0] rgb, input logic fs,
                                          input byte glyph, input int column, input int row,
                                          input bit row_end, input bit frame_end);
        stim_row_t r;
        r = '{kind: ROW_PIXEL, rgb: rgb, frame_start: fs, known: 1'b1, want: '0,
              width: '0, height: '0};
        r.want.glyph = glyph[GLYPH_W-1:0];
        r.want.column = COLUMN_W'(column);
        r.want.row = ROW_W'(row);
        r.want.row_last = row_end;
        r.want.frame_last = frame_end;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_size_row(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        stim_row_t r;
        r = '{kind: ROW_SIZES, rgb: '0, frame_start: 1'b0, known: 1'b0, want: '0,
              width: w, height: h};
        directed_rows.push_back(r);
    endfunction

    function automatic logic [RGB_W-1:0] shaded_pixel();
        return {8'($urandom_range(shade_lo, shade_hi)), 8'($urandom_range(shade_lo, shade_hi)),
                8'($urandom_range(shade_lo, shade_hi))};
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    task automatic send_pixel(input logic [RGB_W-1:0] rgb, input logic starts_frame,
                              input bit known, input cell_word_t want);
        int         gap;
        bit         hit;
        cell_word_t closed;
        gap = source_pauses ? int'($urandom_range(0, 5)) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_pixel_rgb = rgb;
        s_frame_start = starts_frame;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixels_sent++;
        predict_pixel(rgb, starts_frame, hit, closed);
        if (known) begin
            expected_cells.push_back(want);
        end else if (hit) begin
            expected_cells.push_back(closed);
        end
    endtask

    task automatic send_run(input int count, input bit lead_start, input int start_odds);
        logic fs;
        for (int k = 0; k < count; k++) begin
            fs = (k == 0 && lead_start) ||
                 (start_odds > 0 && $urandom_range(1, start_odds) == 1);
            send_pixel(shaded_pixel(), fs, 1'b0, '0);
        end
    endtask

    // Stops offering pixels and lets every pending cell leave, plus a margin
    // for a cell that may still be in the divider.
    task automatic settle_block();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [SIZE_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (index == CFG_FRAME_WIDTH) begin
            width_reg = value;
        end else if (index == CFG_FRAME_HEIGHT) begin
            height_reg = value;
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        write_register(CFG_FRAME_WIDTH, w);
        write_register(CFG_FRAME_HEIGHT, h);
    endtask

    task automatic pick_pacing();
        source_pauses = ($urandom_range(0, 3) != 0);
        sink_pauses = ($urandom_range(0, 3) != 0);
        shade_lo = $urandom_range(0, 255);
        shade_hi = $urandom_range(shade_lo, 255);
    endtask

    always @(posedge aclk) begin : result_check
        cell_word_t want;
        if (aresetn && m_valid && m_ready) begin
            words_taken++;
            if (expected_cells.size() == 0) begin
                note_mismatch("unexpected word, column", int'(m_cell_column), -1);
            end else begin
                want = expected_cells.pop_front();
                if (m_glyph !== want.glyph) begin
                    note_mismatch("glyph", int'(m_glyph), int'(want.glyph));
                end
                if (m_cell_column !== want.column) begin
                    note_mismatch("cell_column", int'(m_cell_column), int'(want.column));
                end
                if (m_cell_row !== want.row) begin
                    note_mismatch("cell_row", int'(m_cell_row), int'(want.row));
                end
                if (m_row_last !== want.row_last) begin
                    note_mismatch("row_last", int'(m_row_last), int'(want.row_last));
                end
                if (m_frame_last !== want.frame_last) begin
                    note_mismatch("frame_last", int'(m_frame_last), int'(want.frame_last));
                end
            end
        end
    end

    initial begin : result_sink
        int words_seen;
        int holds_served;
        int hold_left;
        int stall_left;
        words_seen = 0;
        holds_served = 0;
        hold_left = 0;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (words_seen != words_taken) begin
                words_seen = words_taken;
                stall_left = sink_pauses ? int'($urandom_range(0, 5)) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin : run_limit
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin : stimulus
        int mode;
        int fw;
        int fh;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_pixel_rgb = '0;
        s_frame_start = 1'b0;
        width_reg = SIZE_W'(640);
        height_reg = SIZE_W'(400);
        pos_col = '0;
        pos_line = '0;
        clear_cells();

        add_pixel_row(24'h123456, 1'b1);
        add_pixel_row(24'hFFFFFF, 1'b0);
        add_size_row(SIZE_W'(1), SIZE_W'(1));
        add_known_row(24'h000000, 1'b1, " ", 0, 0, 1'b1, 1'b1);
        add_known_row(24'hFFFFFF, 1'b0, "@", 0, 0, 1'b1, 1'b1);
        add_known_row(24'hFF0000, 1'b0, ":", 0, 0, 1'b1, 1'b1);
        add_known_row(24'h00FF00, 1'b0, "+", 0, 0, 1'b1, 1'b1);
        add_known_row(24'h0000FF, 1'b0, ".", 0, 0, 1'b1, 1'b1);
        add_known_row(24'h808080, 1'b0, "=", 0, 0, 1'b1, 1'b1);
        add_size_row(SIZE_W'(0), SIZE_W'(0));
        add_known_row(24'h000000, 1'b0, " ", 0, 0, 1'b1, 1'b1);
        add_size_row(SIZE_W'(2), SIZE_W'(2));
        add_pixel_row(24'hFFFFFF, 1'b1);
        add_pixel_row(24'h000000, 1'b0);
        add_pixel_row(24'hFFFFFF, 1'b0);
        add_known_row(24'h000000, 1'b0, "=", 0, 0, 1'b1, 1'b1);
        add_size_row(SIZE_W'(9), SIZE_W'(1));
        for (int k = 0; k < 7; k++) begin
            add_pixel_row(24'hFFFFFF, k == 0);
        end
        add_known_row(24'hFFFFFF, 1'b0, "@", 0, 0, 1'b0, 1'b0);
        add_known_row(24'h000000, 1'b0, " ", 1, 0, 1'b1, 1'b1);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_SIZES) begin
                settle_block();
                write_sizes(directed_rows[i].width, directed_rows[i].height);
            end else begin
                send_pixel(directed_rows[i].rgb, directed_rows[i].frame_start,
                           directed_rows[i].known, directed_rows[i].want);
            end
        end

        // One line of the widest frame reaches the last grid column and
        // runs past the grid's right edge.
        settle_block();
        pick_pacing();
        shade_lo = 0;
        shade_hi = 255;
        write_sizes(SIZE_W'(SIZE_MAX), SIZE_W'(1));
        send_run(660, 1'b1, 0);

        // A one-pixel column of the tallest frame reaches the last grid row.
        settle_block();
        pick_pacing();
        write_sizes(SIZE_W'(1), 12'hFFF);
        send_run(410, 1'b1, 0);

        // Three-pixel cells while the sink holds off: the block must back up
        // and stall its pixel input.
        settle_block();
        source_pauses = 1'b0;
        sink_pauses = 1'b0;
        write_sizes(SIZE_W'(3), SIZE_W'(1));
        hold_requests++;
        send_run(90, 1'b1, 0);

        settle_block();
        write_register(CFG_SPARE_LO, SIZE_W'($urandom()));
        write_register(CFG_SPARE_HI, SIZE_W'($urandom()));

        while (pixels_sent < PIXEL_TARGET) begin
            mode = $urandom_range(0, 19);
            settle_block();
            pick_pacing();
            fw = $urandom_range(1, 24);
            fh = (fw <= 6) ? int'($urandom_range(1, 40)) : int'($urandom_range(1, 12));
            if (mode < 14) begin
                write_sizes(SIZE_W'(fw), SIZE_W'(fh));
                repeat ($urandom_range(1, 3)) send_run(fw * fh, 1'b1, 0);
            end else if (mode < 17) begin
                // New size while the position is somewhere inside the old frame.
                write_sizes(SIZE_W'(fw), SIZE_W'(fh));
                send_run($urandom_range(10, 150), 1'b0, 0);
            end else if (mode < 19) begin
                write_sizes(SIZE_W'(fw), SIZE_W'(fh));
                send_run($urandom_range(20, 150), 1'b1, 8);
            end else begin
                write_sizes(SIZE_W'($urandom()), SIZE_W'($urandom()));
                send_run($urandom_range(30, 120), 1'b1, 0);
            end
        end

        settle_block();
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bladsc_pkg.sv
hw/rtl/bladsc_cell_ram.sv
hw/rtl/bladsc_divider.sv
hw/rtl/block_luma_ascii_downsampler_core.sv
tb/sv/tb.sv
